FILE: hw/rtl/lra_pkg.sv
`timescale 1ns / 1ps
// Package for the linear regression accumulator: sizes, status codes,
// the in and out word types and the command word of the shared unit.
// Depends on nothing.
package lra_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_POINTS  = 65535;
    localparam int COUNT_BITS  = 16;
    localparam int COUNT_CAP   = 65535;
    localparam int POINT_LIMIT = (MAX_POINTS < COUNT_CAP) ? MAX_POINTS : COUNT_CAP;

    localparam int SUM1_BITS   = SAMPLE_BITS + 17;
    localparam int SUM2_BITS   = 2 * SAMPLE_BITS + 15;
    localparam int SPREAD_BITS = 2 * SUM1_BITS - 1;
    localparam int WIDE_BITS   = 2 * SPREAD_BITS + 32;
    localparam int ITER_BITS   = $clog2(WIDE_BITS + 1);

    localparam int FRAC_BITS   = 16;
    localparam int QUO_BITS    = 31;
    localparam int PRE_SHIFT   = QUO_BITS - FRAC_BITS;
    localparam int CORR_SHIFT  = 30;
    localparam int ROOT_BITS   = 15;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_DEL = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic                          command;
        logic signed [SAMPLE_BITS-1:0] x_value;
        logic signed [SAMPLE_BITS-1:0] y_value;
    } point_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] point_count;
        logic signed [31:0]    slope;
        logic signed [31:0]    intercept;
        logic signed [15:0]    correlation;
        logic                  fit_valid;
        logic                  corr_valid;
        logic [1:0]            status;
    } fit_t;

    typedef enum logic [2:0] {
        UOP_MUL  = 3'b001,
        UOP_DIV  = 3'b010,
        UOP_SQRT = 3'b100
    } uop_t;

    typedef struct packed {
        uop_t                 op;
        logic [WIDE_BITS-1:0] opa;
        logic [WIDE_BITS-1:0] opb;
        logic [WIDE_BITS-1:0] acc;
        logic [ITER_BITS-1:0] iters;
    } unit_cmd_t;

endpackage

FILE: hw/rtl/lra_unit.sv
`timescale 1ns / 1ps
// Shared radix-2 arithmetic unit: shift-add multiply, restoring divide and
// digit-by-digit square root on unsigned magnitudes, one bit per cycle.
// Depends on lra_pkg.
module lra_unit
    import lra_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  unit_cmd_t            cmd,
    output logic                 busy,
    output logic                 done,
    output logic [WIDE_BITS-1:0] result
);

    localparam int W = WIDE_BITS;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [ITER_BITS-1:0] cnt_reg, cnt_next;
    uop_t                 op_reg, op_next;
    logic [W-1:0]         a_reg, a_next;
    logic [W-1:0]         b_reg, b_next;
    logic [W-1:0]         acc_reg, acc_next;

    logic [W+1:0] lhs;
    logic [W+1:0] rhs;
    logic [W+1:0] sum;
    logic         sub;
    logic         fits;

    always_comb
    begin
        unique case (op_reg)
            UOP_DIV:
            begin
                lhs = {1'b0, acc_reg, a_reg[W-1]};
                rhs = {2'b00, b_reg};
                sub = 1'b1;
            end
            UOP_SQRT:
            begin
                lhs = {acc_reg, a_reg[W-1:W-2]};
                rhs = {b_reg, 2'b01};
                sub = 1'b1;
            end
            default:
            begin
                lhs = {2'b00, acc_reg};
                rhs = {2'b00, a_reg};
                sub = 1'b0;
            end
        endcase
        sum  = lhs + (sub ? ~rhs : rhs) + {{(W+1){1'b0}}, sub};
        fits = !sum[W+1];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = cmd.iters;
            op_next   = cmd.op;
            a_next    = cmd.opa;
            b_next    = cmd.opb;
            acc_next  = cmd.acc;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ITER_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            unique case (op_reg)
                UOP_DIV:
                begin
                    acc_next = fits ? sum[W-1:0] : lhs[W-1:0];
                    a_next   = {a_reg[W-2:0], fits};
                end
                UOP_SQRT:
                begin
                    acc_next = fits ? sum[W-1:0] : lhs[W-1:0];
                    a_next   = {a_reg[W-3:0], 2'b00};
                    b_next   = {b_reg[W-2:0], fits};
                end
                default:
                begin
                    acc_next = b_reg[0] ? sum[W-1:0] : acc_reg;
                    a_next   = {a_reg[W-2:0], 1'b0};
                    b_next   = {1'b0, b_reg[W-1:1]};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= UOP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    always_comb
    begin
        unique case (op_reg)
            UOP_DIV:  result = a_reg;
            UOP_SQRT: result = b_reg;
            default:  result = acc_reg;
        endcase
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

FILE: hw/rtl/linear_regression_accumulator.sv
`timescale 1ns / 1ps
// Least-squares linear regression accumulator, top level.
// Depends on lra_pkg and lra_unit.
//
// Each input word adds or removes one point and yields one result word with
// the count, slope and intercept in Q16.16 and the correlation in Q1.15.
// Sums are updated through one small multiplier, squares of x, then of y,
// then the cross product; the fit is then worked out by a single shared
// bit-serial unit doing up to ten multiplies, three divides and one square
// root in turn, each run for as many iterations as its operand widths need:
// the count or sum width for sum products, the spread width for spread
// products, the quotient width for Q16.16 divides, the correlation shift for
// the correlation ratio and the root width for the root. The next word is
// accepted while the last result still waits in the output register.
module linear_regression_accumulator
    import lra_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   sample_valid,
    output logic   sample_stall,
    input  point_t sample,
    output logic   result_valid,
    input  logic   result_stall,
    output fit_t   result
);

    localparam int W = WIDE_BITS;

    localparam logic [3:0] STEP_NXX   = 4'd0;
    localparam logic [3:0] STEP_XX    = 4'd1;
    localparam logic [3:0] STEP_NYY   = 4'd2;
    localparam logic [3:0] STEP_YY    = 4'd3;
    localparam logic [3:0] STEP_NXY   = 4'd4;
    localparam logic [3:0] STEP_XY    = 4'd5;
    localparam logic [3:0] STEP_YXX   = 4'd6;
    localparam logic [3:0] STEP_XXY   = 4'd7;
    localparam logic [3:0] STEP_SLOPE = 4'd8;
    localparam logic [3:0] STEP_ICPT  = 4'd9;
    localparam logic [3:0] STEP_PP    = 4'd10;
    localparam logic [3:0] STEP_SQR   = 4'd11;
    localparam logic [3:0] STEP_CDIV  = 4'd12;
    localparam logic [3:0] STEP_ROOT  = 4'd13;

    localparam logic [1:0] UPD_XX = 2'd0;
    localparam logic [1:0] UPD_YY = 2'd1;

    localparam logic [ITER_BITS-1:0] IT_COUNT  = ITER_BITS'(COUNT_BITS);
    localparam logic [ITER_BITS-1:0] IT_SUM1   = ITER_BITS'(SUM1_BITS);
    localparam logic [ITER_BITS-1:0] IT_SPREAD = ITER_BITS'(SPREAD_BITS);
    localparam logic [ITER_BITS-1:0] IT_QUO    = ITER_BITS'(QUO_BITS);
    localparam logic [ITER_BITS-1:0] IT_CORR   = ITER_BITS'(CORR_SHIFT);
    localparam logic [ITER_BITS-1:0] IT_ROOT   = ITER_BITS'(ROOT_BITS);

    localparam logic [31:0] Q_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_NEG_MAX = 32'h8000_0000;
    localparam logic [15:0] C_POS_MAX = 16'h7FFF;
    localparam logic [15:0] C_NEG_MAX = 16'h8000;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_ISSUE  = 5'b00100,
        ST_WAIT   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic unit_cmd_t mul_cmd(input logic [W-1:0] a, input logic [W-1:0] b,
                                          input logic [ITER_BITS-1:0] n);
        unit_cmd_t c;
        c.op    = UOP_MUL;
        c.opa   = a;
        c.opb   = b;
        c.acc   = '0;
        c.iters = n;
        return c;
    endfunction

    function automatic unit_cmd_t div_cmd(input logic [W-1:0] rem, input logic [W-1:0] low,
                                          input logic [W-1:0] den,
                                          input logic [ITER_BITS-1:0] n);
        unit_cmd_t c;
        c.op    = UOP_DIV;
        c.opa   = low;
        c.opb   = den;
        c.acc   = rem;
        c.iters = n;
        return c;
    endfunction

    state_t state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       cmd_reg, cmd_next;
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic signed [SAMPLE_BITS-1:0] y_reg, y_next;
    logic [1:0] status_reg, status_next;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [SUM1_BITS-1:0]  sum_x_reg, sum_x_next;
    logic [SUM1_BITS-1:0]  sum_y_reg, sum_y_next;
    logic [SUM2_BITS-1:0]  sum_xx_reg, sum_xx_next;
    logic [SUM2_BITS-1:0]  sum_yy_reg, sum_yy_next;
    logic [SUM2_BITS-1:0]  sum_xy_reg, sum_xy_next;

    logic [W-1:0] p_reg, p_next;
    logic [W-1:0] sxx_reg, sxx_next;
    logic [W-1:0] syy_reg, syy_next;
    logic [W-1:0] sxy_reg, sxy_next;
    logic [W-1:0] num_reg, num_next;
    logic         neg_reg, neg_next;

    logic [31:0] slope_reg, slope_next;
    logic [31:0] icpt_reg, icpt_next;
    logic [15:0] corr_reg, corr_next;
    logic        fv_reg, fv_next;
    logic        cv_reg, cv_next;

    fit_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    logic       accept;
    logic [1:0] accept_status;

    logic signed [SAMPLE_BITS-1:0]   mul_a;
    logic signed [SAMPLE_BITS-1:0]   mul_b;
    logic signed [2*SAMPLE_BITS-1:0] mul_p;
    logic [SUM2_BITS-1:0]            mul_ext;

    logic [W-1:0] n_w, sx_w, sy_w, sxx_w, syy_w, sxy_w;
    logic [W-1:0] mag_sx, mag_sy, mag_sxx, mag_syy, mag_sxy, mag_num;
    logic [W-1:0] res_neg, res_acc;
    logic [31:0]  quo;
    logic [15:0]  root;

    unit_cmd_t    unit_cmd;
    logic         unit_start;
    logic         unit_busy;
    logic         unit_done;
    logic [W-1:0] unit_result;

    lra_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (unit_start),
        .cmd    (unit_cmd),
        .busy   (unit_busy),
        .done   (unit_done),
        .result (unit_result)
    );

    assign accept = sample_valid && !sample_stall;

    always_comb
    begin
        priority if (sample.command == CMD_DEL && count_reg == '0)
            accept_status = STATUS_EMPTY;
        else if (sample.command == CMD_ADD && 32'(count_reg) >= POINT_LIMIT)
            accept_status = STATUS_FULL;
        else
            accept_status = STATUS_OK;
    end

    always_comb
    begin
        mul_a   = (step_reg[1:0] == UPD_YY) ? y_reg : x_reg;
        mul_b   = (step_reg[1:0] == UPD_XX) ? x_reg : y_reg;
        mul_p   = mul_a * mul_b;
        mul_ext = SUM2_BITS'(mul_p);
    end

    always_comb
    begin
        n_w   = W'(count_reg);
        sx_w  = {{(W-SUM1_BITS){sum_x_reg[SUM1_BITS-1]}}, sum_x_reg};
        sy_w  = {{(W-SUM1_BITS){sum_y_reg[SUM1_BITS-1]}}, sum_y_reg};
        sxx_w = {{(W-SUM2_BITS){sum_xx_reg[SUM2_BITS-1]}}, sum_xx_reg};
        syy_w = {{(W-SUM2_BITS){sum_yy_reg[SUM2_BITS-1]}}, sum_yy_reg};
        sxy_w = {{(W-SUM2_BITS){sum_xy_reg[SUM2_BITS-1]}}, sum_xy_reg};
        mag_sx  = mag_of(sx_w);
        mag_sy  = mag_of(sy_w);
        mag_sxx = mag_of(sxx_reg);
        mag_syy = mag_of(syy_reg);
        mag_sxy = mag_of(sxy_reg);
        mag_num = mag_of(num_reg);
        res_neg = neg_reg ? (~unit_result + 1'b1) : unit_result;
        res_acc = neg_reg ? (p_reg + unit_result) : (p_reg - unit_result);
        quo     = {1'b0, unit_result[QUO_BITS-1:0]};
        root    = {1'b0, unit_result[ROOT_BITS-1:0]};
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd_next       = cmd_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        sum_xx_next    = sum_xx_reg;
        sum_yy_next    = sum_yy_reg;
        sum_xy_next    = sum_xy_reg;
        p_next         = p_reg;
        sxx_next       = sxx_reg;
        syy_next       = syy_reg;
        sxy_next       = sxy_reg;
        num_next       = num_reg;
        neg_next       = neg_reg;
        slope_next     = slope_reg;
        icpt_next      = icpt_reg;
        corr_next      = corr_reg;
        fv_next        = fv_reg;
        cv_next        = cv_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        unit_start     = 1'b0;
        unit_cmd       = mul_cmd(n_w, mag_sx, IT_COUNT);

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = sample.command;
                    x_next      = sample.x_value;
                    y_next      = sample.y_value;
                    status_next = accept_status;
                    step_next   = '0;
                    slope_next  = '0;
                    icpt_next   = '0;
                    corr_next   = '0;
                    fv_next     = 1'b0;
                    cv_next     = 1'b0;
                    state_next  = (accept_status == STATUS_OK) ? ST_UPDATE : ST_ISSUE;
                end
            end
            ST_UPDATE:
            begin
                step_next = step_reg + 1'b1;
                priority if (step_reg[1:0] == UPD_XX)
                begin
                    if (cmd_reg == CMD_DEL)
                    begin
                        count_next  = count_reg - 1'b1;
                        sum_x_next  = sum_x_reg - SUM1_BITS'(x_reg);
                        sum_y_next  = sum_y_reg - SUM1_BITS'(y_reg);
                        sum_xx_next = sum_xx_reg - mul_ext;
                    end
                    else
                    begin
                        count_next  = count_reg + 1'b1;
                        sum_x_next  = sum_x_reg + SUM1_BITS'(x_reg);
                        sum_y_next  = sum_y_reg + SUM1_BITS'(y_reg);
                        sum_xx_next = sum_xx_reg + mul_ext;
                    end
                end
                else if (step_reg[1:0] == UPD_YY)
                begin
                    sum_yy_next = (cmd_reg == CMD_DEL) ? sum_yy_reg - mul_ext
                                                       : sum_yy_reg + mul_ext;
                end
                else
                begin
                    sum_xy_next = (cmd_reg == CMD_DEL) ? sum_xy_reg - mul_ext
                                                       : sum_xy_reg + mul_ext;
                    step_next   = '0;
                    state_next  = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
                unit_start = 1'b1;
                unique case (step_reg)
                    STEP_NXX:
                    begin
                        if (count_reg < COUNT_BITS'(2))
                        begin
                            unit_start = 1'b0;
                            state_next = ST_FINISH;
                        end
                        unit_cmd = mul_cmd(mag_of(sxx_w), n_w, IT_COUNT);
                        neg_next = sxx_w[W-1];
                    end
                    STEP_XX:
                    begin
                        unit_cmd = mul_cmd(mag_sx, mag_sx, IT_SUM1);
                        neg_next = 1'b0;
                    end
                    STEP_NYY:
                    begin
                        unit_cmd = mul_cmd(mag_of(syy_w), n_w, IT_COUNT);
                        neg_next = syy_w[W-1];
                    end
                    STEP_YY:
                    begin
                        unit_cmd = mul_cmd(mag_sy, mag_sy, IT_SUM1);
                        neg_next = 1'b0;
                    end
                    STEP_NXY:
                    begin
                        unit_cmd = mul_cmd(mag_of(sxy_w), n_w, IT_COUNT);
                        neg_next = sxy_w[W-1];
                    end
                    STEP_XY:
                    begin
                        unit_cmd = mul_cmd(mag_sx, mag_sy, IT_SUM1);
                        neg_next = sx_w[W-1] ^ sy_w[W-1];
                    end
                    STEP_YXX:
                    begin
                        unit_cmd = mul_cmd(mag_of(sxx_w), mag_sy, IT_SUM1);
                        neg_next = sy_w[W-1] ^ sxx_w[W-1];
                    end
                    STEP_XXY:
                    begin
                        unit_cmd = mul_cmd(mag_of(sxy_w), mag_sx, IT_SUM1);
                        neg_next = sx_w[W-1] ^ sxy_w[W-1];
                    end
                    STEP_SLOPE:
                    begin
                        neg_next = sxy_reg[W-1] ^ sxx_reg[W-1];
                        unit_cmd = div_cmd(mag_sxy >> PRE_SHIFT, mag_sxy << (W - PRE_SHIFT),
                                           mag_sxx, IT_QUO);
                        if (mag_sxy >= (mag_sxx << PRE_SHIFT))
                        begin
                            unit_start = 1'b0;
                            slope_next = (sxy_reg[W-1] ^ sxx_reg[W-1]) ? Q_NEG_MAX : Q_POS_MAX;
                            step_next  = step_reg + 1'b1;
                            state_next = ST_ISSUE;
                        end
                    end
                    STEP_ICPT:
                    begin
                        neg_next = num_reg[W-1] ^ sxx_reg[W-1];
                        unit_cmd = div_cmd(mag_num >> PRE_SHIFT, mag_num << (W - PRE_SHIFT),
                                           mag_sxx, IT_QUO);
                        if (mag_num >= (mag_sxx << PRE_SHIFT))
                        begin
                            unit_start = 1'b0;
                            icpt_next  = (num_reg[W-1] ^ sxx_reg[W-1]) ? Q_NEG_MAX : Q_POS_MAX;
                            step_next  = step_reg + 1'b1;
                            state_next = (syy_reg == '0) ? ST_FINISH : ST_ISSUE;
                        end
                    end
                    STEP_PP:
                    begin
                        unit_cmd = mul_cmd(mag_sxx, mag_syy, IT_SPREAD);
                        neg_next = 1'b0;
                    end
                    STEP_SQR:
                    begin
                        unit_cmd = mul_cmd(mag_sxy, mag_sxy, IT_SPREAD);
                        neg_next = 1'b0;
                    end
                    STEP_CDIV:
                    begin
                        unit_cmd = div_cmd(num_reg, '0, p_reg, IT_CORR);
                        neg_next = sxy_reg[W-1];
                        if (num_reg >= p_reg)
                        begin
                            unit_start = 1'b0;
                            corr_next  = sxy_reg[W-1] ? C_NEG_MAX : C_POS_MAX;
                            cv_next    = 1'b1;
                            state_next = ST_FINISH;
                        end
                    end
                    STEP_ROOT:
                    begin
                        unit_cmd.op    = UOP_SQRT;
                        unit_cmd.opa   = num_reg << (W - CORR_SHIFT);
                        unit_cmd.opb   = '0;
                        unit_cmd.acc   = '0;
                        unit_cmd.iters = IT_ROOT;
                        neg_next       = sxy_reg[W-1];
                    end
                    default:
                    begin
                        unit_start = 1'b0;
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_WAIT:
            begin
                if (unit_done)
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_ISSUE;
                    unique case (step_reg)
                        STEP_XX:
                        begin
                            sxx_next = res_acc;
                            fv_next  = (res_acc != '0);
                            if (res_acc == '0)
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                        STEP_YY:    syy_next = res_acc;
                        STEP_XY:    sxy_next = res_acc;
                        STEP_XXY:   num_next = res_acc;
                        STEP_SLOPE: slope_next = neg_reg ? (~quo + 1'b1) : quo;
                        STEP_ICPT:
                        begin
                            icpt_next = neg_reg ? (~quo + 1'b1) : quo;
                            if (syy_reg == '0)
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                        STEP_PP:    p_next = unit_result;
                        STEP_SQR:   num_next = unit_result;
                        STEP_CDIV:  num_next = unit_result;
                        STEP_ROOT:
                        begin
                            corr_next  = neg_reg ? (~root + 1'b1) : root;
                            cv_next    = 1'b1;
                            state_next = ST_FINISH;
                        end
                        default:    p_next = res_neg;
                    endcase
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next.point_count = count_reg;
                    out_next.slope       = slope_reg;
                    out_next.intercept   = icpt_reg;
                    out_next.correlation = corr_reg;
                    out_next.fit_valid   = fv_reg;
                    out_next.corr_valid  = cv_reg;
                    out_next.status      = status_reg;
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_xx_reg    <= '0;
            sum_yy_reg    <= '0;
            sum_xy_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            sum_xx_reg    <= sum_xx_next;
            sum_yy_reg    <= sum_yy_next;
            sum_xy_reg    <= sum_xy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        status_reg <= status_next;
        p_reg      <= p_next;
        sxx_reg    <= sxx_next;
        syy_reg    <= syy_next;
        sxy_reg    <= sxy_next;
        num_reg    <= num_next;
        neg_reg    <= neg_next;
        slope_reg  <= slope_next;
        icpt_reg   <= icpt_next;
        corr_reg   <= corr_next;
        fv_reg     <= fv_next;
        cv_reg     <= cv_next;
        out_reg    <= out_next;
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // A rejected word must leave the count and the sums untouched.
    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && accept_status != STATUS_OK)
        |=> ($stable(count_reg) && $stable(sum_x_reg) && $stable(sum_xy_reg)))
        else $error("rejected word changed the sums");

    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        unit_start |-> !unit_busy)
        else $error("shared unit started while busy");

    a_wait_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT) |-> (unit_busy || unit_done))
        else $error("waiting on an idle shared unit");

    a_corr_fit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.corr_valid)
        |-> (result.fit_valid && result.point_count >= COUNT_BITS'(2)))
        else $error("correlation flagged valid without a valid fit");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the least-squares linear regression accumulator.
// Depends on lra_pkg and linear_regression_accumulator; it predicts every result
// word with wide integer arithmetic and compares each field as the words come out.
module testbench;
    import lra_pkg::*;

    localparam int  RANDOM_WORDS = 500;
    localparam int  POOL_MAX     = 40;
    localparam int  DRAIN_CYCLES = 1500;
    localparam int  CYCLE_LIMIT  = 3000000;
    localparam int  HOLD_START   = 40000;
    localparam int  HOLD_CYCLES  = 6000;

    typedef logic signed [255:0] wide_t;

    logic   clk;
    logic   rst_n;
    logic   sample_valid;
    logic   sample_stall;
    point_t sample;
    logic   result_valid;
    logic   result_stall;
    fit_t   result;

    point_t pending_words[$];
    fit_t   expected_fits[$];
    point_t point_pool[$];

    logic [COUNT_BITS-1:0]       fit_count;
    logic signed [SUM1_BITS-1:0] fit_sum_x;
    logic signed [SUM1_BITS-1:0] fit_sum_y;
    logic signed [SUM2_BITS-1:0] fit_sum_xx;
    logic signed [SUM2_BITS-1:0] fit_sum_yy;
    logic signed [SUM2_BITS-1:0] fit_sum_xy;

    int total_words;
    int accepted_words;
    int checked_words;
    int error_count;
    int rejected_words;
    int valid_fits;
    int valid_corrs;
    int cycle_count;
    int burst_left;
    int gap_left;
    int stall_mode;
    int stall_cycles;

    linear_regression_accumulator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    function automatic logic signed [31:0] saturate_q16(input wide_t v);
        if (v > wide_t'(32'sh7FFFFFFF))
            return 32'sh7FFFFFFF;
        if (v < -wide_t'(64'sh80000000))
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic fit_t fit_from_sums();
        fit_t  r;
        wide_t n;
        wide_t sx;
        wide_t sy;
        wide_t sxx;
        wide_t syy;
        wide_t sxy;
        wide_t num;
        logic [255:0] prod;
        logic [255:0] rhs;
        logic [255:0] lhs;
        logic [255:0] ax;
        logic [255:0] ay;
        logic [255:0] axy;
        int lo;
        int hi;
        int mid;
        r = '0;
        r.point_count = fit_count;
        if (fit_count >= 2)
        begin
            n   = fit_count;
            sx  = fit_sum_x;
            sy  = fit_sum_y;
            sxx = n * wide_t'(fit_sum_xx) - sx * sx;
            if (sxx != 0)
            begin
                r.fit_valid = 1'b1;
                syy = n * wide_t'(fit_sum_yy) - sy * sy;
                sxy = n * wide_t'(fit_sum_xy) - sx * sy;
                r.slope = saturate_q16((sxy <<< 16) / sxx);
                num = sy * wide_t'(fit_sum_xx) - sx * wide_t'(fit_sum_xy);
                r.intercept = saturate_q16((num <<< 16) / sxx);
                if (syy != 0)
                begin
                    r.corr_valid = 1'b1;
                    ax   = (sxx < 0) ? -sxx : sxx;
                    ay   = (syy < 0) ? -syy : syy;
                    axy  = (sxy < 0) ? -sxy : sxy;
                    prod = ax * ay;
                    rhs  = (axy * axy) << 30;
                    lo = 0;
                    hi = 32768;
                    while (lo < hi)
                    begin
                        mid = (lo + hi + 1) / 2;
                        lhs = prod * 256'(mid) * 256'(mid);
                        if (lhs <= rhs)
                            lo = mid;
                        else
                            hi = mid - 1;
                    end
                    if (sxy < 0)
                        r.correlation = 16'(-lo);
                    else
                        r.correlation = (lo > 32767) ? 16'sd32767 : 16'(lo);
                end
            end
        end
        return r;
    endfunction

    task automatic apply_point(input point_t p);
        fit_t r;
        logic [1:0] code;
        logic signed [SUM2_BITS-1:0] pxx;
        logic signed [SUM2_BITS-1:0] pyy;
        logic signed [SUM2_BITS-1:0] pxy;
        code = STATUS_OK;
        pxx = p.x_value * p.x_value;
        pyy = p.y_value * p.y_value;
        pxy = p.x_value * p.y_value;
        if (p.command == CMD_DEL && fit_count == 0)
        begin
            code = STATUS_EMPTY;
        end
        else if (p.command == CMD_ADD && fit_count >= POINT_LIMIT)
        begin
            code = STATUS_FULL;
        end
        else if (p.command == CMD_ADD)
        begin
            fit_count  = fit_count + 1;
            fit_sum_x  = fit_sum_x + p.x_value;
            fit_sum_y  = fit_sum_y + p.y_value;
            fit_sum_xx = fit_sum_xx + pxx;
            fit_sum_yy = fit_sum_yy + pyy;
            fit_sum_xy = fit_sum_xy + pxy;
        end
        else
        begin
            fit_count  = fit_count - 1;
            fit_sum_x  = fit_sum_x - p.x_value;
            fit_sum_y  = fit_sum_y - p.y_value;
            fit_sum_xx = fit_sum_xx - pxx;
            fit_sum_yy = fit_sum_yy - pyy;
            fit_sum_xy = fit_sum_xy - pxy;
        end
        r = fit_from_sums();
        r.status = code;
        if (code != STATUS_OK)
            rejected_words++;
        if (r.fit_valid)
            valid_fits++;
        if (r.corr_valid)
            valid_corrs++;
        expected_fits.push_back(r);
    endtask

    task automatic queue_point(input logic cmd, input int x, input int y);
        point_t p;
        p.command = cmd;
        p.x_value = x[SAMPLE_BITS-1:0];
        p.y_value = y[SAMPLE_BITS-1:0];
        pending_words.push_back(p);
    endtask

    task automatic queue_random_point();
        int pick;
        int idx;
        int x;
        int y;
        int slope_int;
        point_t p;
        pick = $urandom_range(0, 99);
        if (point_pool.size() > 0 && (pick < 35 || point_pool.size() > POOL_MAX))
        begin
            idx = $urandom_range(0, point_pool.size() - 1);
            p = point_pool[idx];
            point_pool.delete(idx);
            p.command = CMD_DEL;
            pending_words.push_back(p);
        end
        else if (pick < 39)
        begin
            queue_point(CMD_DEL, $urandom_range(0, 65535), $urandom_range(0, 65535));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    x = $urandom_range(0, 65535);
                    y = $urandom_range(0, 65535);
                end
                1:
                begin
                    x = $urandom_range(0, 200) - 100;
                    y = $urandom_range(0, 200) - 100;
                end
                2:
                begin
                    x = $urandom_range(0, 2000) - 1000;
                    slope_int = $urandom_range(0, 20) - 10;
                    y = slope_int * x + $urandom_range(0, 6) - 3;
                end
                default:
                begin
                    x = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
                    y = $urandom_range(0, 65535);
                end
            endcase
            queue_point(CMD_ADD, x, y);
            point_pool.push_back(pending_words[$]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample       <= '0;
            burst_left   = 0;
            gap_left     = 0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                apply_point(sample);
                accepted_words++;
            end
            if (sample_valid && sample_stall)
            begin
                sample_valid <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                sample_valid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                sample       <= pending_words.pop_front();
                sample_valid <= 1'b1;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_mode   = 0;
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles % 2000 == 0)
                stall_mode = $urandom_range(0, 2);
            if (stall_cycles >= HOLD_START && stall_cycles < HOLD_START + HOLD_CYCLES)
                result_stall <= 1'b1;
            else if (stall_mode == 1)
                result_stall <= ($urandom_range(0, 9) < 3);
            else if (stall_mode == 2)
                result_stall <= ($urandom_range(0, 9) < 8);
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        fit_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_fits.size() == 0)
            begin
                $error("unexpected result word");
                error_count++;
            end
            else
            begin
                want = expected_fits.pop_front();
                checked_words++;
                if (result.point_count !== want.point_count)
                begin
                    $error("point_count expected %0d actual %0d",
                           want.point_count, result.point_count);
                    error_count++;
                end
                if (result.slope !== want.slope)
                begin
                    $error("slope expected %0d actual %0d", want.slope, result.slope);
                    error_count++;
                end
                if (result.intercept !== want.intercept)
                begin
                    $error("intercept expected %0d actual %0d",
                           want.intercept, result.intercept);
                    error_count++;
                end
                if (result.correlation !== want.correlation)
                begin
                    $error("correlation expected %0d actual %0d",
                           want.correlation, result.correlation);
                    error_count++;
                end
                if (result.fit_valid !== want.fit_valid)
                begin
                    $error("fit_valid expected %0b actual %0b",
                           want.fit_valid, result.fit_valid);
                    error_count++;
                end
                if (result.corr_valid !== want.corr_valid)
                begin
                    $error("corr_valid expected %0b actual %0b",
                           want.corr_valid, result.corr_valid);
                    error_count++;
                end
                if (result.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, result.status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        fit_count = '0;
        fit_sum_x = '0;
        fit_sum_y = '0;
        fit_sum_xx = '0;
        fit_sum_yy = '0;
        fit_sum_xy = '0;
        accepted_words = 0;
        checked_words = 0;
        error_count = 0;
        rejected_words = 0;
        valid_fits = 0;
        valid_corrs = 0;
        cycle_count = 0;

        queue_point(CMD_DEL, 0, 0);
        queue_point(CMD_ADD, -32768, -32768);
        queue_point(CMD_ADD, -32768, -32768);
        queue_point(CMD_ADD, 32767, 32767);
        queue_point(CMD_ADD, 32767, -32768);
        queue_point(CMD_DEL, -32768, -32768);
        queue_point(CMD_DEL, 32767, -32768);
        queue_point(CMD_DEL, 32767, 32767);
        queue_point(CMD_DEL, -32768, -32768);
        queue_point(CMD_DEL, 5, 5);
        queue_point(CMD_ADD, 1, 7);
        queue_point(CMD_ADD, 2, 7);
        queue_point(CMD_ADD, 3, 7);
        queue_point(CMD_ADD, 4, -9);
        queue_point(CMD_DEL, 30000, -30000);
        queue_point(CMD_DEL, -1, 1);
        queue_point(CMD_ADD, 0, 0);
        queue_point(CMD_DEL, 1, 7);
        queue_point(CMD_DEL, 2, 7);
        queue_point(CMD_DEL, 3, 7);
        queue_point(CMD_DEL, 4, -9);
        queue_point(CMD_ADD, 10, 20);
        queue_point(CMD_ADD, 20, 40);
        queue_point(CMD_ADD, 30, 61);
        for (int i = 0; i < RANDOM_WORDS; i++)
            queue_random_point();
        total_words = pending_words.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (accepted_words == total_words && expected_fits.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_fits.size() != 0)
        begin
            $error("%0d result words never arrived", expected_fits.size());
            error_count++;
        end
        $display("Checked %0d result words, %0d of them rejected.",
                 checked_words, rejected_words);
        $display("%0d carried a valid fit and %0d a valid correlation.",
                 valid_fits, valid_corrs);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/lra_pkg.sv
hw/rtl/lra_unit.sv
hw/rtl/linear_regression_accumulator.sv
bench/testbench.sv
